FILE: sv/spd_pkg.sv
package spd_pkg;

    localparam int PKT_LEN = 14;
    localparam int BODY_LEN = PKT_LEN - 1;

    localparam logic [1:0] MODE_SERIAL = 2'd0;
    localparam logic [1:0] MODE_DGRAM = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_SERIAL = 2'd1;
    localparam logic [1:0] SRC_DGRAM = 2'd2;

    localparam logic [1:0] EVT_NONE = 2'd0;
    localparam logic [1:0] EVT_ACCEPT = 2'd1;
    localparam logic [1:0] EVT_REJECT = 2'd2;

    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_TIMEOUT_MS = 1'b1;

    localparam logic [7:0] START_BYTE_RESET = 8'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [16:0] AGE_MAX = 17'h1FFFF;

    // Byte 0 is the start byte, byte 13 the check byte.
    typedef logic [PKT_LEN-1:0][7:0] pkt_t;

    typedef struct packed {
        logic done;
        pkt_t bytes;
    } frame_t;

    function automatic logic pkt_good(input pkt_t pkt, input logic [7:0] start_byte);
        logic [7:0] x;
        x = 8'd0;
        for (int i = 0; i < BODY_LEN; i++)
        begin
            x = x ^ pkt[i];
        end
        return (pkt[0] == start_byte) && (x == pkt[PKT_LEN-1]);
    endfunction

    function automatic logic [31:0] le_word(input pkt_t pkt, input int base);
        return {pkt[base+3], pkt[base+2], pkt[base+1], pkt[base]};
    endfunction

endpackage

FILE: sv/spd_serial_rx.sv
module spd_serial_rx (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [1:0]        mode,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        start_byte,
    output spd_pkg::frame_t   frame
);
    import spd_pkg::*;

    logic                        hunting_reg;
    logic                        hunting_next;
    logic [3:0]                  count_reg;
    logic [3:0]                  count_next;
    logic [BODY_LEN-1:0][7:0]    bytes_reg;
    logic                        take;
    logic                        last;

    always_comb
    begin
        take = advance && (mode == MODE_SERIAL);
        last = !hunting_reg && (count_reg == 4'(BODY_LEN));
        hunting_next = hunting_reg;
        count_next = count_reg;
        if (take)
        begin
            if (hunting_reg)
            begin
                if (data_byte == start_byte)
                begin
                    count_next = 4'd1;
                    hunting_next = 1'b0;
                end
            end
            else if (last)
            begin
                // full frame seen: hunt again, collected bytes are not rescanned
                count_next = 4'd0;
                hunting_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 4'd1;
            end
        end
        frame.done = take && last;
        frame.bytes = {data_byte, bytes_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            count_reg <= 4'd0;
        end
        else
        begin
            hunting_reg <= hunting_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (hunting_reg ? (data_byte == start_byte) : !last))
        begin
            bytes_reg[count_next - 4'd1] <= data_byte;
        end
    end

endmodule

FILE: sv/spd_dgram_rx.sv
module spd_dgram_rx (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [1:0]        mode,
    input  logic [7:0]        data_byte,
    input  logic              datagram_end,
    output spd_pkg::frame_t   frame
);
    import spd_pkg::*;

    logic [3:0] count_reg;
    logic [3:0] count_next;
    pkt_t       bytes_reg;
    logic       take;
    logic       room;

    always_comb
    begin
        take = advance && (mode == MODE_DGRAM);
        room = count_reg < 4'(PKT_LEN);
        count_next = count_reg;
        if (take)
        begin
            if (datagram_end)
            begin
                count_next = 4'd0;
            end
            else if (room)
            begin
                count_next = count_reg + 4'd1;
            end
        end
        // check byte arrives with the end mark when the datagram is exactly full
        frame.done = take && datagram_end && (count_reg >= 4'(BODY_LEN));
        frame.bytes = bytes_reg;
        if (count_reg == 4'(BODY_LEN))
        begin
            frame.bytes[PKT_LEN-1] = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && room)
        begin
            bytes_reg[count_reg] <= data_byte;
        end
    end

endmodule

FILE: sv/spd_commit.sv
module spd_commit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [1:0]        mode,
    input  logic [7:0]        start_byte,
    input  logic [15:0]       timeout_ms,
    input  spd_pkg::frame_t   serial_frame,
    input  spd_pkg::frame_t   dgram_frame,
    output logic [31:0]       vx_bits,
    output logic [31:0]       vy_bits,
    output logic [31:0]       wz_bits,
    output logic [1:0]        active_source,
    output logic [1:0]        frame_event
);
    import spd_pkg::*;

    logic [31:0] vx_held_reg, vx_held_next;
    logic [31:0] vy_held_reg, vy_held_next;
    logic [31:0] wz_held_reg, wz_held_next;
    logic [1:0]  src_held_reg, src_held_next;
    logic        ever_reg, ever_next;
    logic [16:0] age_reg, age_next;
    logic [31:0] vx_out_reg, vy_out_reg, wz_out_reg;
    logic [1:0]  src_out_reg, evt_out_reg;
    logic [1:0]  evt_next;
    logic        fresh;
    frame_t      frame;
    logic [1:0]  frame_src;

    always_comb
    begin
        frame = serial_frame.done ? serial_frame : dgram_frame;
        frame_src = serial_frame.done ? SRC_SERIAL : SRC_DGRAM;
        vx_held_next = vx_held_reg;
        vy_held_next = vy_held_reg;
        wz_held_next = wz_held_reg;
        src_held_next = src_held_reg;
        ever_next = ever_reg;
        age_next = age_reg;
        evt_next = EVT_NONE;
        if (frame.done)
        begin
            if (pkt_good(frame.bytes, start_byte))
            begin
                vx_held_next = le_word(frame.bytes, 1);
                vy_held_next = le_word(frame.bytes, 5);
                wz_held_next = le_word(frame.bytes, 9);
                src_held_next = frame_src;
                ever_next = 1'b1;
                age_next = 17'd0;
                evt_next = EVT_ACCEPT;
            end
            else
            begin
                evt_next = EVT_REJECT;
            end
        end
        else if (advance && (mode == MODE_TICK) && (age_reg != AGE_MAX))
        begin
            age_next = age_reg + 17'd1;
        end
        fresh = ever_next && (age_next <= {1'b0, timeout_ms});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_held_reg <= 32'd0;
            vy_held_reg <= 32'd0;
            wz_held_reg <= 32'd0;
            src_held_reg <= SRC_NONE;
            ever_reg <= 1'b0;
            age_reg <= 17'd0;
        end
        else if (advance)
        begin
            vx_held_reg <= vx_held_next;
            vy_held_reg <= vy_held_next;
            wz_held_reg <= wz_held_next;
            src_held_reg <= src_held_next;
            ever_reg <= ever_next;
            age_reg <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vx_out_reg <= fresh ? vx_held_next : 32'd0;
            vy_out_reg <= fresh ? vy_held_next : 32'd0;
            wz_out_reg <= fresh ? wz_held_next : 32'd0;
            src_out_reg <= fresh ? src_held_next : SRC_NONE;
            evt_out_reg <= evt_next;
        end
    end

    assign vx_bits = vx_out_reg;
    assign vy_bits = vy_out_reg;
    assign wz_bits = wz_out_reg;
    assign active_source = src_out_reg;
    assign frame_event = evt_out_reg;

endmodule

FILE: sv/setpoint_packet_deframer.sv
// Setpoint packet deframer. Each beat is a serial byte (mode 0), a datagram byte
// (mode 1, datagram_end on its last byte) or a one millisecond tick (mode 2), and
// each beat yields exactly one result beat showing the committed vx/vy/wz words
// and their source after that beat, plus whether it completed a good or bad
// 14-byte packet. Words read as zero with source none before the first good
// packet and once more than timeout_ms ticks have passed since the last one.
// One beat is taken every cycle while item_stall is low; a beat passes through the
// input register and then the result register, and waits in the input register
// while result_stall holds the result register. Write start_byte and
// timeout_ms only while no beat is in flight.
module setpoint_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        datagram_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] vx_bits,
    output logic [31:0] vy_bits,
    output logic [31:0] wz_bits,
    output logic [1:0]  active_source,
    output logic [1:0]  frame_event,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import spd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic        result_valid_reg, result_valid_next;
    logic [1:0]  mode_reg;
    logic [7:0]  byte_reg;
    logic        dend_reg;
    logic [7:0]  start_byte_reg;
    logic [15:0] timeout_reg;
    logic        advance;
    logic        accept;
    frame_t      serial_frame;
    frame_t      dgram_frame;

    always_comb
    begin
        advance = in_valid_reg && !(result_valid_reg && result_stall);
        item_stall = in_valid_reg && !advance;
        accept = item_valid && !item_stall;
        in_valid_next = accept || (in_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            start_byte_reg <= START_BYTE_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_BYTE: start_byte_reg <= cfg_data[7:0];
                    CFG_TIMEOUT_MS: timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
            dend_reg <= datagram_end;
        end
    end

    spd_serial_rx u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .mode       (mode_reg),
        .data_byte  (byte_reg),
        .start_byte (start_byte_reg),
        .frame      (serial_frame)
    );

    spd_dgram_rx u_dgram (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .mode         (mode_reg),
        .data_byte    (byte_reg),
        .datagram_end (dend_reg),
        .frame        (dgram_frame)
    );

    spd_commit u_commit (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .mode          (mode_reg),
        .start_byte    (start_byte_reg),
        .timeout_ms    (timeout_reg),
        .serial_frame  (serial_frame),
        .dgram_frame   (dgram_frame),
        .vx_bits       (vx_bits),
        .vy_bits       (vy_bits),
        .wz_bits       (wz_bits),
        .active_source (active_source),
        .frame_event   (frame_event)
    );

endmodule

FILE: sv/spd_checker.sv
module spd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] vx_bits,
    input logic [31:0] vy_bits,
    input logic [31:0] wz_bits,
    input logic [1:0]  active_source,
    input logic [1:0]  frame_event
);
    import spd_pkg::*;

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(vx_bits)
            && $stable(vy_bits) && $stable(wz_bits) && $stable(active_source)
            && $stable(frame_event))
    else $error("stalled result beat changed");

    // a stale or empty view shows zero words
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (active_source == SRC_NONE) |->
            (vx_bits == 32'd0) && (vy_bits == 32'd0) && (wz_bits == 32'd0))
    else $error("nonzero words with no source");

    // a packet just accepted cannot be stale
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (frame_event == EVT_ACCEPT) |-> (active_source != SRC_NONE))
    else $error("accepted packet shows no source");

endmodule

bind setpoint_packet_deframer spd_checker u_spd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .vx_bits       (vx_bits),
    .vy_bits       (vy_bits),
    .wz_bits       (wz_bits),
    .active_source (active_source),
    .frame_event   (frame_event)
);

FILE: sim/tb_setpoint_packet_deframer.sv
module tb_setpoint_packet_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS = 50;
    localparam int LONG_AGE_TICKS = 110;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] wz;
        logic [1:0]  src;
        logic [1:0]  evt;
    } setpoint_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  mode = MODE_SERIAL;
    logic [7:0]  data_byte = 8'h00;
    logic        datagram_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] vx_bits;
    logic [31:0] vy_bits;
    logic [31:0] wz_bits;
    logic [1:0]  active_source;
    logic [1:0]  frame_event;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_START_BYTE;
    logic [15:0] cfg_data = 16'h0000;

    // deframer state as the testbench sees it
    logic [7:0]  start_byte_cfg = START_BYTE_RESET;
    logic [15:0] timeout_cfg = TIMEOUT_RESET;
    logic        ser_hunting = 1'b1;
    int          ser_count = 0;
    pkt_t        ser_buf = '0;
    int          dg_count = 0;
    pkt_t        dg_buf = '0;
    logic [31:0] held_vx = '0;
    logic [31:0] held_vy = '0;
    logic [31:0] held_wz = '0;
    logic [1:0]  held_src = SRC_NONE;
    logic        got_packet = 1'b0;
    logic [16:0] age_ms = '0;

    setpoint_view_t pending_views[$];
    setpoint_view_t want_view;
    logic [7:0]  serial_stream[$];
    logic [8:0]  dgram_stream[$];   // {end mark, byte}

    int  err_count = 0;
    int  result_idx = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  stall_left = 0;

    setpoint_packet_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .data_byte    (data_byte),
        .datagram_end (datagram_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .vx_bits      (vx_bits),
        .vy_bits      (vy_bits),
        .wz_bits      (wz_bits),
        .active_source(active_source),
        .frame_event  (frame_event),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic pkt_t build_packet(input logic [7:0] sb, input logic [31:0] vx,
                                          input logic [31:0] vy, input logic [31:0] wz);
        pkt_t p;
        logic [7:0] x;
        p = '0;
        p[0] = sb;
        p[4:1] = vx;
        p[8:5] = vy;
        p[12:9] = wz;
        x = 8'h00;
        for (int i = 0; i < PKT_LEN - 1; i++)
        begin
            x = x ^ p[i];
        end
        p[PKT_LEN-1] = x;
        return p;
    endfunction

    // Check a complete packet against the live start byte; commit it when good.
    task automatic judge_packet(input pkt_t p, input logic [1:0] src, output logic [1:0] evt);
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < PKT_LEN - 1; i++)
        begin
            x = x ^ p[i];
        end
        if (p[0] != start_byte_cfg || x != p[PKT_LEN-1])
        begin
            evt = EVT_REJECT;
        end
        else
        begin
            held_vx = p[4:1];
            held_vy = p[8:5];
            held_wz = p[12:9];
            held_src = src;
            got_packet = 1'b1;
            age_ms = '0;
            evt = EVT_ACCEPT;
        end
    endtask

    task automatic advance_deframer(input logic [1:0] m, input logic [7:0] b, input logic e);
        logic [1:0] evt;
        logic fresh;
        setpoint_view_t v;
        evt = EVT_NONE;
        case (m)
            MODE_SERIAL:
            begin
                if (ser_hunting)
                begin
                    if (b == start_byte_cfg)
                    begin
                        ser_buf[0] = b;
                        ser_count = 1;
                        ser_hunting = 1'b0;
                    end
                end
                else
                begin
                    ser_buf[ser_count] = b;
                    ser_count++;
                    if (ser_count == PKT_LEN)
                    begin
                        judge_packet(ser_buf, SRC_SERIAL, evt);
                        ser_count = 0;
                        ser_hunting = 1'b1;
                    end
                end
            end
            MODE_DGRAM:
            begin
                if (dg_count < PKT_LEN)
                begin
                    dg_buf[dg_count] = b;
                    dg_count++;
                end
                if (e)
                begin
                    if (dg_count == PKT_LEN)
                    begin
                        judge_packet(dg_buf, SRC_DGRAM, evt);
                    end
                    dg_count = 0;
                end
            end
            MODE_TICK:
            begin
                if (age_ms != AGE_MAX)
                begin
                    age_ms = age_ms + 17'd1;
                end
            end
            default:
            begin
            end
        endcase
        fresh = got_packet && (age_ms <= {1'b0, timeout_cfg});
        v.vx = fresh ? held_vx : 32'd0;
        v.vy = fresh ? held_vy : 32'd0;
        v.wz = fresh ? held_wz : 32'd0;
        v.src = fresh ? held_src : SRC_NONE;
        v.evt = evt;
        pending_views.push_back(v);
    endtask

    task automatic send_beat(input logic [1:0] m, input logic [7:0] b, input logic e);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        data_byte <= b;
        datagram_end <= e;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        advance_deframer(m, b, e);
    endtask

    task automatic send_serial_bytes(input pkt_t p, input int first, input int last);
        for (int i = first; i <= last; i++)
        begin
            send_beat(MODE_SERIAL, p[i], 1'($urandom_range(0, 1)));
        end
    endtask

    // Bytes past the packet length are filler; the end mark goes on the last one.
    task automatic send_datagram(input pkt_t p, input int len);
        for (int i = 0; i < len; i++)
        begin
            send_beat(MODE_DGRAM, (i < PKT_LEN) ? p[i] : 8'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_START_BYTE)
        begin
            start_byte_cfg = val[7:0];
        end
        else
        begin
            timeout_cfg = val;
        end
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [15:0] to);
        wait_idle();
        write_reg(CFG_START_BYTE, {8'h00, sb});
        write_reg(CFG_TIMEOUT_MS, to);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS)
        begin
            $display("mismatch on result %0d, %s: got %h, want %h", result_idx, what, got, want);
        end
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_views.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'd0, 32'd0);
            end
            else
            begin
                want_view = pending_views.pop_front();
                if (vx_bits !== want_view.vx)
                    report_mismatch("vx_bits", vx_bits, want_view.vx);
                if (vy_bits !== want_view.vy)
                    report_mismatch("vy_bits", vy_bits, want_view.vy);
                if (wz_bits !== want_view.wz)
                    report_mismatch("wz_bits", wz_bits, want_view.wz);
                if (active_source !== want_view.src)
                    report_mismatch("active_source", 32'(active_source), 32'(want_view.src));
                if (frame_event !== want_view.evt)
                    report_mismatch("frame_event", 32'(frame_event), 32'(want_view.evt));
            end
            result_idx++;
        end
    end

    // Result side: short random stalls, plus one long hold on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack <= hold_req;
            stall_left <= LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Reset defaults: unused mode, ignored fields, a short datagram, then a
    // serial packet with the reset start byte and extreme words.
    task automatic test_reset_defaults();
        send_beat(MODE_UNUSED, 8'hFF, 1'b1);
        send_beat(MODE_TICK, 8'hFF, 1'b1);
        send_beat(MODE_SERIAL, 8'h81, 1'b1);
        send_beat(MODE_DGRAM, 8'h7E, 1'b1);
        send_serial_bytes(build_packet(START_BYTE_RESET, 32'hFFFF_FFFF, 32'h0000_0000,
                                       32'h8000_0001), 0, PKT_LEN - 1);
        send_beat(MODE_UNUSED, 8'h00, 1'b0);
    endtask

    task automatic test_datagram_lengths();
        pkt_t p;
        set_config(8'hFF, 16'd100);
        p = build_packet(8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
        send_datagram(p, 3);
        send_datagram(p, PKT_LEN + 2);
    endtask

    task automatic test_start_byte_change();
        pkt_t p;
        p = build_packet(8'hFF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        send_serial_bytes(p, 0, 5);
        set_config(8'h00, 16'd100);
        send_serial_bytes(p, 6, PKT_LEN - 1);
    endtask

    task automatic test_stale_view();
        set_config(8'h3C, 16'd0);
        send_datagram(build_packet(8'h3C, 32'hCAFE_0001, 32'h0000_FFFF, 32'hFFFF_0000), PKT_LEN);
        send_beat(MODE_TICK, 8'h55, 1'b0);
        set_config(8'h3C, 16'd2);
        repeat (3) send_beat(MODE_TICK, 8'hAA, 1'b1);
    endtask

    // Hold the result side long enough that the block backs up into its input.
    task automatic test_backpressure();
        set_config(8'hA5, 16'd100);
        tx_idle_en = 1'b0;
        hold_req++;
        repeat (3)
        begin
            send_serial_bytes(build_packet(8'hA5, $urandom, $urandom, $urandom), 0, PKT_LEN - 1);
        end
        tx_idle_en = 1'b1;
        wait_idle();
    endtask

    // Age one packet across the default timeout with ticks back to back.
    task automatic test_long_aging();
        set_config(8'h00, 16'd100);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_datagram(build_packet(8'h00, $urandom, $urandom, $urandom), PKT_LEN);
        for (int i = 0; i < LONG_AGE_TICKS; i++)
        begin
            send_beat(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic refill_serial_stream();
        pkt_t p;
        int r;
        r = $urandom_range(0, 99);
        p = build_packet(start_byte_cfg, $urandom, $urandom, $urandom);
        if (r < 85)
        begin
            repeat ($urandom_range(0, 3))
                serial_stream.push_back(start_byte_cfg ^ 8'($urandom_range(1, 255)));
            if (r >= 65)
                p[$urandom_range(1, PKT_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
            for (int k = 0; k < PKT_LEN; k++)
                serial_stream.push_back(p[k]);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                serial_stream.push_back(8'($urandom));
        end
    endtask

    task automatic refill_dgram_stream();
        pkt_t p;
        int r;
        int len;
        r = $urandom_range(0, 99);
        p = build_packet(start_byte_cfg, $urandom, $urandom, $urandom);
        len = PKT_LEN;
        if (r >= 50 && r < 60)
            len = PKT_LEN + $urandom_range(1, 6);
        else if (r >= 60 && r < 75)
            p[$urandom_range(0, PKT_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        else if (r >= 75 && r < 90)
            len = $urandom_range(1, PKT_LEN - 1);
        else if (r >= 90)
        begin
            p = pkt_t'({$urandom, $urandom, $urandom, $urandom});
            len = $urandom_range(1, PKT_LEN + 6);
        end
        for (int k = 0; k < len; k++)
            dgram_stream.push_back({k == len - 1, (k < PKT_LEN) ? p[k] : 8'($urandom)});
    endtask

    // Serial and datagram streams interleave byte by byte with ticks in between.
    task automatic run_traffic(input int beats);
        int r;
        logic [8:0] w;
        for (int n = 0; n < beats; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
            begin
                if (serial_stream.size() == 0)
                    refill_serial_stream();
                send_beat(MODE_SERIAL, serial_stream.pop_front(), 1'($urandom_range(0, 1)));
            end
            else if (r < 84)
            begin
                if (dgram_stream.size() == 0)
                    refill_dgram_stream();
                w = dgram_stream.pop_front();
                send_beat(MODE_DGRAM, w[7:0], w[8]);
            end
            else if (r < 97)
                send_beat(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
            else
                send_beat(MODE_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        set_config(8'hA5, 16'd100);
        run_traffic(350);
        set_config(8'hFF, 16'd0);
        run_traffic(250);
        set_config(8'($urandom), 16'($urandom_range(1, 40)));
        run_traffic(350);
        set_config(8'h00, 16'hFFFF);
        run_traffic(250);
        // drain with no idling on either side
        set_config(8'($urandom), 16'($urandom_range(5, 30)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_traffic(300);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_datagram_lengths();
        test_start_byte_change();
        test_stale_view();
        test_backpressure();
        test_long_aging();
        test_random_traffic();
        wait_idle();
        if (err_count == 0 && pending_views.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/spd_pkg.sv
sv/spd_serial_rx.sv
sv/spd_dgram_rx.sv
sv/spd_commit.sv
sv/setpoint_packet_deframer.sv
sv/spd_checker.sv
sim/tb_setpoint_packet_deframer.sv
